// ===== rtl/wase_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wase_pkg
// Shared constants, codes and controller/datapath interface types for the
// weekly/annual schedule evaluator.
// ----------------------------------------------------------------------------
package wase_pkg;

   localparam int WEEKLY_COUNT_DEF = 16;
   localparam int ANNUAL_COUNT_DEF = 16;

   localparam int DAY_TYPES    = 9;
   localparam int EVENTS       = 8;
   localparam int BITMAP_BYTES = 46;
   localparam int VALID_BYTE_A = 11;
   localparam int VALID_BYTE_B = 38;

   localparam logic [7:0] UNUSED_BYTE  = 8'hff;
   localparam logic [7:0] HOL_TWO_MARK = 8'h10;
   localparam logic [7:0] HOL_ONE_MARK = 8'h20;
   localparam int         MANUAL_BIT   = 7;
   localparam int         VALUE_BIT    = 6;

   localparam logic [3:0] DAY_HOL_ONE = 4'd7;
   localparam logic [3:0] DAY_HOL_TWO = 4'd8;

   localparam logic [2:0] CMD_WR_EVENT  = 3'd0;
   localparam logic [2:0] CMD_WR_DESC   = 3'd1;
   localparam logic [2:0] CMD_WR_BITMAP = 3'd2;
   localparam logic [2:0] CMD_WR_FLAG   = 3'd3;
   localparam logic [2:0] CMD_EVALUATE  = 3'd4;

   typedef struct packed {
      logic accept;
      logic clr_step;
      logic ann_rd;
      logic ann_upd;
      logic wk_sel;
      logic ev_rd;
      logic ev_cmp;
      logic wk_upd;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic ann_last;
      logic wk_scan;
      logic ev_stop;
      logic wk_last;
      logic rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/wase_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wase_ctrl
// Sequencer: clearing pass, annual walk, weekly walk with event scan, and
// result hand-off.
// ----------------------------------------------------------------------------
module wase_ctrl
   import wase_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [2:0]    req_command,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_ANN_RD  = 9'b000000100,
      ST_ANN_UPD = 9'b000001000,
      ST_WK_SEL  = 9'b000010000,
      ST_EV_RD   = 9'b000100000,
      ST_EV_CMP  = 9'b001000000,
      ST_WK_UPD  = 9'b010000000,
      ST_RESP    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.accept   = accept;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_command == CMD_EVALUATE) ? ST_ANN_RD : ST_RESP;
            end
         end
         ST_ANN_RD: begin
            cmd.ann_rd = 1'b1;
            state_in   = ST_ANN_UPD;
         end
         ST_ANN_UPD: begin
            cmd.ann_upd = 1'b1;
            state_in    = status.ann_last ? ST_WK_SEL : ST_ANN_RD;
         end
         ST_WK_SEL: begin
            cmd.wk_sel = 1'b1;
            state_in   = status.wk_scan ? ST_EV_RD : ST_WK_UPD;
         end
         ST_EV_RD: begin
            cmd.ev_rd = 1'b1;
            state_in  = ST_EV_CMP;
         end
         ST_EV_CMP: begin
            cmd.ev_cmp = 1'b1;
            state_in   = status.ev_stop ? ST_WK_UPD : ST_EV_RD;
         end
         ST_WK_UPD: begin
            cmd.wk_upd = 1'b1;
            state_in   = status.wk_last ? ST_RESP : ST_WK_SEL;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

// ===== rtl/wase_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wase_dpath
// Schedule stores, state bits, walk counters and the result register.
// ----------------------------------------------------------------------------
module wase_dpath
   import wase_pkg::*;
#(
   parameter int WEEKLY_COUNT = WEEKLY_COUNT_DEF,
   parameter int ANNUAL_COUNT = ANNUAL_COUNT_DEF
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire dp_cmd_type cmd,
   output dp_status_type   status,
   input  wire logic [2:0] req_command,
   input  wire logic [3:0] req_weekly_index,
   input  wire logic [3:0] req_annual_index,
   input  wire logic [3:0] req_day_type,
   input  wire logic [2:0] req_event_index,
   input  wire logic [8:0] req_position,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [4:0] req_holiday_one,
   input  wire logic [4:0] req_holiday_two,
   input  wire logic [4:0] req_hour,
   input  wire logic [5:0] req_minute,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [15:0]     rsp_weekly_on,
   output logic [15:0]     rsp_annual_on,
   output logic [15:0]     rsp_holiday_one_hit,
   output logic [15:0]     rsp_holiday_two_hit,
   output logic            rsp_weekly_toggled,
   output logic            rsp_annual_toggled
);

   localparam int W         = WEEKLY_COUNT;
   localparam int A         = ANNUAL_COUNT;
   localparam int WIW       = (W > 1) ? $clog2(W) : 1;
   localparam int AIW       = (A > 1) ? $clog2(A) : 1;
   localparam int EV_DEPTH  = W * DAY_TYPES * EVENTS;
   localparam int BM_DEPTH  = A * BITMAP_BYTES;
   localparam int EAW       = $clog2(EV_DEPTH);
   localparam int BAW       = $clog2(BM_DEPTH);
   localparam int CLR_DEPTH = (EV_DEPTH > BM_DEPTH) ? EV_DEPTH : BM_DEPTH;
   localparam int CW        = $clog2(CLR_DEPTH + 1);

   logic [10:0] ev_mem [EV_DEPTH];
   logic [7:0]  bm_mem [BM_DEPTH];

   logic [CW-1:0]  clr_cnt_ff;
   logic [AIW-1:0] ann_cnt_ff;
   logic [WIW-1:0] wk_cnt_ff;
   logic [2:0]     ev_cnt_ff;

   logic [3:0]  day_ff;
   logic [5:0]  byte_ff;
   logic [2:0]  bit_ff;
   logic [10:0] now_ff;
   logic        eval_ff;
   logic [3:0]  w_ff;
   logic [7:0]  f_ff;
   logic        on_ff;
   logic [10:0] ev_data_ff;
   logic [7:0]  bm_data_ff;

   logic [7:0] desc_flag_ff [W];
   logic [4:0] desc_h1_ff   [W];
   logic [4:0] desc_h2_ff   [W];
   logic [7:0] ann_flag_ff  [A];
   logic [A-1:0] b_ok_a_ff, b_ok_b_ff;

   logic [W-1:0] weekly_bits_ff, hol1_bits_ff, hol2_bits_ff;
   logic [A-1:0] annual_bits_ff;
   logic [W-1:0] weekly_snap_ff, hol1_snap_ff, hol2_snap_ff;
   logic [A-1:0] annual_snap_ff;

   logic wr_event, wr_desc, wr_bitmap, wr_flag;
   logic clr_ev, clr_bm;
   logic ev_we, bm_we;
   logic [EAW-1:0] ev_waddr, ev_raddr;
   logic [BAW-1:0] bm_waddr, bm_raddr;
   logic [10:0]    ev_wdata;
   logic [7:0]     bm_wdata;

   logic [7:0] cur_flag, cur_aflag;
   logic [4:0] cur_h1, cur_h2, h1m1, h2m1;
   logic       h1_ok, h2_ok, hit1, hit2;
   logic [3:0] w_in;
   logic [7:0] f_in;
   logic       marked, ev_hit;

   // write decode
   assign wr_event  = cmd.accept && req_command == CMD_WR_EVENT &&
                      5'(req_weekly_index) < 5'(W) && req_day_type < 4'(DAY_TYPES);
   assign wr_desc   = cmd.accept && req_command == CMD_WR_DESC &&
                      5'(req_weekly_index) < 5'(W);
   assign wr_bitmap = cmd.accept && req_command == CMD_WR_BITMAP &&
                      5'(req_annual_index) < 5'(A) && req_position < 9'(BITMAP_BYTES);
   assign wr_flag   = cmd.accept && req_command == CMD_WR_FLAG &&
                      5'(req_annual_index) < 5'(A);

   assign clr_ev = cmd.clr_step && clr_cnt_ff < CW'(EV_DEPTH);
   assign clr_bm = cmd.clr_step && clr_cnt_ff < CW'(BM_DEPTH);

   assign ev_we    = clr_ev | wr_event;
   assign ev_waddr = clr_ev ? EAW'(clr_cnt_ff) :
                     EAW'((int'(req_weekly_index) * DAY_TYPES + int'(req_day_type)) * EVENTS
                          + int'(req_event_index));
   assign ev_wdata = clr_ev ? 11'd0 : {req_hour, req_minute};
   assign ev_raddr = EAW'((int'(wk_cnt_ff) * DAY_TYPES + int'(w_ff)) * EVENTS
                          + int'(ev_cnt_ff));

   assign bm_we    = clr_bm | wr_bitmap;
   assign bm_waddr = clr_bm ? BAW'(clr_cnt_ff) :
                     BAW'(int'(req_annual_index) * BITMAP_BYTES + int'(req_position));
   assign bm_wdata = clr_bm ? UNUSED_BYTE : req_data_byte;
   assign bm_raddr = BAW'(int'(ann_cnt_ff) * BITMAP_BYTES + int'(byte_ff));

   always_ff @(posedge clock) begin
      if (ev_we) ev_mem[ev_waddr] <= ev_wdata;
      if (cmd.ev_rd) ev_data_ff <= ev_mem[ev_raddr];
   end

   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
      if (cmd.ann_rd) bm_data_ff <= bm_mem[bm_raddr];
   end

   // annual step
   assign cur_aflag = ann_flag_ff[ann_cnt_ff];
   assign marked    = b_ok_a_ff[ann_cnt_ff] && b_ok_b_ff[ann_cnt_ff] &&
                      byte_ff < 6'(BITMAP_BYTES) && bm_data_ff[bit_ff];

   // weekly select
   assign cur_flag = desc_flag_ff[wk_cnt_ff];
   assign cur_h1   = desc_h1_ff[wk_cnt_ff];
   assign cur_h2   = desc_h2_ff[wk_cnt_ff];
   assign h1m1     = cur_h1 - 5'd1;
   assign h2m1     = cur_h2 - 5'd1;
   assign h1_ok    = cur_h1 != 5'd0 && 6'(cur_h1) <= 6'(A);
   assign h2_ok    = cur_h2 != 5'd0 && 6'(cur_h2) <= 6'(A);
   assign hit2     = h2_ok && annual_bits_ff[h2m1[AIW-1:0]];
   assign hit1     = h1_ok && annual_bits_ff[h1m1[AIW-1:0]];
   assign w_in     = hit1 ? DAY_HOL_ONE : (hit2 ? DAY_HOL_TWO : day_ff);
   assign f_in     = cur_flag | (h2_ok ? HOL_TWO_MARK : 8'd0) | (h1_ok ? HOL_ONE_MARK : 8'd0);

   assign ev_hit = ev_data_ff != 11'd0 && now_ff >= ev_data_ff;

   assign status.clr_last = clr_cnt_ff == CW'(CLR_DEPTH - 1);
   assign status.ann_last = ann_cnt_ff == AIW'(A - 1);
   assign status.wk_scan  = !f_in[MANUAL_BIT] && w_in < 4'(DAY_TYPES);
   assign status.ev_stop  = ev_hit || ev_cnt_ff == 3'd0;
   assign status.wk_last  = wk_cnt_ff == WIW'(W - 1);
   assign status.rsp_free = !rsp_valid || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff     <= '0;
         ann_cnt_ff     <= '0;
         wk_cnt_ff      <= '0;
         ev_cnt_ff      <= '0;
         eval_ff        <= 1'b0;
         on_ff          <= 1'b0;
         rsp_valid      <= 1'b0;
         b_ok_a_ff      <= '0;
         b_ok_b_ff      <= '0;
         weekly_bits_ff <= '0;
         hol1_bits_ff   <= '0;
         hol2_bits_ff   <= '0;
         annual_bits_ff <= '0;
         for (int i = 0; i < W; i++) begin
            desc_flag_ff[i] <= UNUSED_BYTE;
            desc_h1_ff[i]   <= '0;
            desc_h2_ff[i]   <= '0;
         end
         for (int i = 0; i < A; i++) begin
            ann_flag_ff[i] <= UNUSED_BYTE;
         end
      end else begin
         if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + CW'(1);

         if (cmd.accept) begin
            eval_ff        <= req_command == CMD_EVALUATE;
            day_ff         <= req_day_type;
            byte_ff        <= req_position[8:3];
            bit_ff         <= req_position[2:0];
            now_ff         <= {req_hour, req_minute};
            ann_cnt_ff     <= '0;
            wk_cnt_ff      <= '0;
            weekly_snap_ff <= weekly_bits_ff;
            hol1_snap_ff   <= hol1_bits_ff;
            hol2_snap_ff   <= hol2_bits_ff;
            annual_snap_ff <= annual_bits_ff;
         end
         if (wr_desc) begin
            desc_flag_ff[WIW'(req_weekly_index)] <= req_data_byte;
            desc_h1_ff[WIW'(req_weekly_index)]   <= req_holiday_one;
            desc_h2_ff[WIW'(req_weekly_index)]   <= req_holiday_two;
         end
         if (wr_flag) ann_flag_ff[AIW'(req_annual_index)] <= req_data_byte;
         if (wr_bitmap && req_position == 9'(VALID_BYTE_A))
            b_ok_a_ff[AIW'(req_annual_index)] <= req_data_byte != UNUSED_BYTE;
         if (wr_bitmap && req_position == 9'(VALID_BYTE_B))
            b_ok_b_ff[AIW'(req_annual_index)] <= req_data_byte != UNUSED_BYTE;

         if (cmd.ann_upd) begin
            if (!cur_aflag[MANUAL_BIT])
               annual_bits_ff[ann_cnt_ff] <= marked;
            else if (cur_aflag != UNUSED_BYTE)
               annual_bits_ff[ann_cnt_ff] <= cur_aflag[VALUE_BIT];
            ann_cnt_ff <= ann_cnt_ff + AIW'(1);
         end

         if (cmd.wk_sel) begin
            w_ff                    <= w_in;
            f_ff                    <= f_in;
            hol2_bits_ff[wk_cnt_ff] <= hit2;
            hol1_bits_ff[wk_cnt_ff] <= hit1;
            ev_cnt_ff               <= 3'(EVENTS - 1);
            on_ff                   <= 1'b0;
         end

         if (cmd.ev_cmp) begin
            if (ev_hit) on_ff <= !ev_cnt_ff[0];
            ev_cnt_ff <= ev_cnt_ff - 3'd1;
         end

         if (cmd.wk_upd) begin
            if (!f_ff[MANUAL_BIT])
               weekly_bits_ff[wk_cnt_ff] <= on_ff;
            else if (f_ff != UNUSED_BYTE)
               weekly_bits_ff[wk_cnt_ff] <= f_ff[VALUE_BIT];
            wk_cnt_ff <= wk_cnt_ff + WIW'(1);
         end

         if (cmd.rsp_load) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_weekly_on       <= 16'(weekly_bits_ff);
         rsp_annual_on       <= 16'(annual_bits_ff);
         rsp_holiday_one_hit <= 16'(hol1_bits_ff);
         rsp_holiday_two_hit <= 16'(hol2_bits_ff);
         rsp_weekly_toggled  <= eval_ff && (weekly_snap_ff != weekly_bits_ff ||
                                hol1_snap_ff != hol1_bits_ff ||
                                hol2_snap_ff != hol2_bits_ff);
         rsp_annual_toggled  <= eval_ff && annual_snap_ff != annual_bits_ff;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/weekly_annual_schedule_evaluator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// weekly_annual_schedule_evaluator
// Weekly on/off schedules with annual holiday calendars. One beat in, one
// result beat out per request.
// ----------------------------------------------------------------------------
// After reset the block sweeps its event and bitmap memories over
// max(WEEKLY_COUNT*72, ANNUAL_COUNT*46) addresses (1152 at the defaults) with
// req_ready low. A write command goes straight to the result hand-off. An
// evaluate walks the annual calendars one at a time, then each weekly
// schedule, reading events from the single event memory port (up to 8,
// from index 7 down, stopping at the first match), then loads the result
// register once the output is free. A new request is taken once the previous
// result is in the output register.
// ----------------------------------------------------------------------------
module weekly_annual_schedule_evaluator
   import wase_pkg::*;
#(
   parameter int WEEKLY_COUNT = WEEKLY_COUNT_DEF,
   parameter int ANNUAL_COUNT = ANNUAL_COUNT_DEF
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_command,
   input  wire logic [3:0] req_weekly_index,
   input  wire logic [3:0] req_annual_index,
   input  wire logic [3:0] req_day_type,
   input  wire logic [2:0] req_event_index,
   input  wire logic [8:0] req_position,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [4:0] req_holiday_one,
   input  wire logic [4:0] req_holiday_two,
   input  wire logic [4:0] req_hour,
   input  wire logic [5:0] req_minute,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [15:0]     rsp_weekly_on,
   output logic [15:0]     rsp_annual_on,
   output logic [15:0]     rsp_holiday_one_hit,
   output logic [15:0]     rsp_holiday_two_hit,
   output logic            rsp_weekly_toggled,
   output logic            rsp_annual_toggled
);

   dp_cmd_type    cmd;
   dp_status_type status;

   wase_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd)
   );

   wase_dpath #(
      .WEEKLY_COUNT (WEEKLY_COUNT),
      .ANNUAL_COUNT (ANNUAL_COUNT)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_command         (req_command),
      .req_weekly_index    (req_weekly_index),
      .req_annual_index    (req_annual_index),
      .req_day_type        (req_day_type),
      .req_event_index     (req_event_index),
      .req_position        (req_position),
      .req_data_byte       (req_data_byte),
      .req_holiday_one     (req_holiday_one),
      .req_holiday_two     (req_holiday_two),
      .req_hour            (req_hour),
      .req_minute          (req_minute),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_weekly_on       (rsp_weekly_on),
      .rsp_annual_on       (rsp_annual_on),
      .rsp_holiday_one_hit (rsp_holiday_one_hit),
      .rsp_holiday_two_hit (rsp_holiday_two_hit),
      .rsp_weekly_toggled  (rsp_weekly_toggled),
      .rsp_annual_toggled  (rsp_annual_toggled)
   );

endmodule
`default_nettype wire

// ===== tb/sv/tb_weekly_annual_schedule_evaluator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weekly_annual_schedule_evaluator
// Drives write and evaluate beats into the schedule evaluator and checks every
// result beat against a behavioral model of the calendars and weekly tables.
// ----------------------------------------------------------------------------
module tb_weekly_annual_schedule_evaluator;
   import wase_pkg::*;

   localparam int NW = 16;
   localparam int NA = 16;
   localparam int N_RANDOM = 1030;

   typedef struct packed {
      logic [2:0] command;
      logic [3:0] weekly_index;
      logic [3:0] annual_index;
      logic [3:0] day_type;
      logic [2:0] event_index;
      logic [8:0] position;
      logic [7:0] data_byte;
      logic [4:0] holiday_one;
      logic [4:0] holiday_two;
      logic [4:0] hour;
      logic [5:0] minute;
   } sched_req_t;

   localparam int REQ_W = $bits(sched_req_t);

   typedef struct packed {
      logic [15:0] weekly_on;
      logic [15:0] annual_on;
      logic [15:0] holiday_one_hit;
      logic [15:0] holiday_two_hit;
      logic        weekly_toggled;
      logic        annual_toggled;
   } sched_rsp_t;

   typedef struct {
      sched_req_t beat;
      bit         has_rsp;
      sched_rsp_t rsp;
   } table_row_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_command = '0;
   logic [3:0] req_weekly_index = '0;
   logic [3:0] req_annual_index = '0;
   logic [3:0] req_day_type = '0;
   logic [2:0] req_event_index = '0;
   logic [8:0] req_position = '0;
   logic [7:0] req_data_byte = '0;
   logic [4:0] req_holiday_one = '0;
   logic [4:0] req_holiday_two = '0;
   logic [4:0] req_hour = '0;
   logic [5:0] req_minute = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [15:0] rsp_weekly_on, rsp_annual_on, rsp_holiday_one_hit, rsp_holiday_two_hit;
   logic rsp_weekly_toggled, rsp_annual_toggled;

   weekly_annual_schedule_evaluator DUT (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      #50ms;
      $display("weekly_annual_schedule_evaluator regression: fail");
      $finish;
   end

   // schedule model state
   logic [10:0] ev_time [NW][9][8];
   logic [7:0]  wk_flag [NW];
   logic [4:0]  wk_hol1 [NW];
   logic [4:0]  wk_hol2 [NW];
   logic [7:0]  cal_map [NA][46];
   logic [7:0]  cal_flag [NA];
   logic [15:0] weekly_bits, annual_bits, hol1_bits, hol2_bits;

   sched_rsp_t  expected_rsps[$];
   sched_rsp_t  typed_rsps[$];
   bit          typed_valid[$];
   int          n_errors = 0;
   bit          long_hold = 0;

   function automatic sched_rsp_t schedule_step(sched_req_t b);
      sched_rsp_t r;
      logic [15:0] a0, w0, o0, t0;
      logic [7:0] f;
      logic [3:0] w;
      logic hit, on;
      int bidx;
      r = '0;
      case (b.command)
         CMD_WR_EVENT:
            if (b.day_type < DAY_TYPES)
               ev_time[b.weekly_index][b.day_type][b.event_index] = {b.hour, b.minute};
         CMD_WR_DESC: begin
            wk_flag[b.weekly_index] = b.data_byte;
            wk_hol1[b.weekly_index] = b.holiday_one;
            wk_hol2[b.weekly_index] = b.holiday_two;
         end
         CMD_WR_BITMAP:
            if (b.position < BITMAP_BYTES) cal_map[b.annual_index][b.position] = b.data_byte;
         CMD_WR_FLAG: cal_flag[b.annual_index] = b.data_byte;
         CMD_EVALUATE: begin
            a0 = annual_bits; w0 = weekly_bits; o0 = hol1_bits; t0 = hol2_bits;
            for (int a = 0; a < NA; a++) begin
               f = cal_flag[a];
               if (!f[MANUAL_BIT]) begin
                  bidx = b.position >> 3;
                  annual_bits[a] = cal_map[a][VALID_BYTE_A] != UNUSED_BYTE
                     && cal_map[a][VALID_BYTE_B] != UNUSED_BYTE && bidx < BITMAP_BYTES
                     && cal_map[a][bidx][b.position[2:0]];
               end else if (f != UNUSED_BYTE) begin
                  annual_bits[a] = f[VALUE_BIT];
               end
            end
            for (int i = 0; i < NW; i++) begin
               w = b.day_type;
               f = wk_flag[i];
               hit = 0;
               if (wk_hol2[i] >= 1 && wk_hol2[i] <= NA) begin
                  f |= HOL_TWO_MARK;
                  hit = annual_bits[wk_hol2[i] - 1];
                  if (hit) w = DAY_HOL_TWO;
               end
               hol2_bits[i] = hit;
               hit = 0;
               if (wk_hol1[i] >= 1 && wk_hol1[i] <= NA) begin
                  f |= HOL_ONE_MARK;
                  hit = annual_bits[wk_hol1[i] - 1];
                  if (hit) w = DAY_HOL_ONE;
               end
               hol1_bits[i] = hit;
               if (!f[MANUAL_BIT]) begin
                  on = 0;
                  if (w < DAY_TYPES) begin
                     for (int j = 7; j >= 0; j--) begin
                        if (ev_time[i][w][j] != 0 && {b.hour, b.minute} >= ev_time[i][w][j]) begin
                           on = (j % 2) == 0;
                           break;
                        end
                     end
                  end
                  weekly_bits[i] = on;
               end else if (f != UNUSED_BYTE) begin
                  weekly_bits[i] = f[VALUE_BIT];
               end
            end
            r.annual_toggled = a0 != annual_bits;
            r.weekly_toggled = w0 != weekly_bits || o0 != hol1_bits || t0 != hol2_bits;
         end
         default: ;
      endcase
      r.weekly_on = weekly_bits;
      r.annual_on = annual_bits;
      r.holiday_one_hit = hol1_bits;
      r.holiday_two_hit = hol2_bits;
      return r;
   endfunction

   function automatic sched_req_t make_beat(logic [2:0] c, logic [3:0] wi, logic [3:0] ai,
                                            logic [3:0] dt, logic [2:0] ei, logic [8:0] p,
                                            logic [7:0] d, logic [4:0] h1, logic [4:0] h2,
                                            logic [4:0] hr, logic [5:0] mn);
      return '{c, wi, ai, dt, ei, p, d, h1, h2, hr, mn};
   endfunction

   function automatic sched_req_t random_beat();
      sched_req_t b;
      int k;
      b = REQ_W'({$urandom, $urandom});
      b.weekly_index = 4'($urandom_range(0, 15));
      b.annual_index = 4'($urandom_range(0, 15));
      b.hour = 5'($urandom_range(0, 23));
      b.minute = 6'($urandom_range(0, 59));
      b.holiday_one = 5'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3));
      b.holiday_two = 5'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3));
      k = $urandom_range(0, 99);
      if (k < 30) begin
         b.command = CMD_WR_EVENT;
         b.day_type = 4'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 8));
      end else if (k < 40) begin
         b.command = CMD_WR_DESC;
         b.data_byte = 8'(($urandom_range(0, 1)) ? $urandom_range(0, 63) : $urandom);
      end else if (k < 60) begin
         b.command = CMD_WR_BITMAP;
         b.position = 9'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 45));
      end else if (k < 66) begin
         b.command = CMD_WR_FLAG;
         b.data_byte = 8'(($urandom_range(0, 1)) ? $urandom_range(0, 127) : $urandom);
      end else if (k < 97) begin
         b.command = CMD_EVALUATE;
         b.day_type = 4'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6));
         b.position = 9'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 365));
      end else begin
         b.command = 3'($urandom_range(5, 7));
      end
      return b;
   endfunction

   task automatic send_beat(sched_req_t b, bit has_rsp, sched_rsp_t tr);
      expected_rsps.push_back(schedule_step(b));
      typed_rsps.push_back(tr);
      typed_valid.push_back(has_rsp);
      {req_command, req_weekly_index, req_annual_index, req_day_type, req_event_index,
       req_position, req_data_byte, req_holiday_one, req_holiday_two, req_hour,
       req_minute} <= b;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_gap();
      int g;
      g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   initial begin
      table_row_t rows[$];
      sched_req_t b;
      for (int i = 0; i < NW; i++) begin
         wk_flag[i] = UNUSED_BYTE; wk_hol1[i] = 0; wk_hol2[i] = 0;
         for (int d = 0; d < 9; d++)
            for (int e = 0; e < 8; e++) ev_time[i][d][e] = 0;
      end
      for (int a = 0; a < NA; a++) begin
         cal_flag[a] = UNUSED_BYTE;
         for (int y = 0; y < 46; y++) cal_map[a][y] = UNUSED_BYTE;
      end
      weekly_bits = 0; annual_bits = 0; hol1_bits = 0; hol2_bits = 0;

      rows.push_back('{make_beat(CMD_EVALUATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '0});
      rows.push_back('{make_beat(3'd7, 15, 15, 15, 7, 511, 255, 31, 31, 31, 63), 1, '0});
      rows.push_back('{make_beat(CMD_WR_FLAG, 0, 0, 0, 0, 0, 8'hc0, 0, 0, 0, 0), 1, '0});
      rows.push_back('{make_beat(CMD_WR_FLAG, 0, 15, 0, 0, 0, 8'h00, 0, 0, 0, 0), 1, 'x});
      rows.push_back('{make_beat(CMD_WR_BITMAP, 0, 15, 0, 0, 11, 8'h00, 0, 0, 0, 0), 1, 'x});
      rows.push_back('{make_beat(CMD_WR_BITMAP, 0, 15, 0, 0, 38, 8'h00, 0, 0, 0, 0), 1, 'x});
      rows.push_back('{make_beat(CMD_WR_BITMAP, 0, 15, 0, 0, 45, 8'h80, 0, 0, 0, 0), 1, 'x});
      rows.push_back('{make_beat(CMD_WR_BITMAP, 0, 15, 0, 0, 46, 8'h00, 0, 0, 0, 0), 1, 'x});
      rows.push_back('{make_beat(CMD_WR_DESC, 0, 0, 0, 0, 0, 8'h00, 0, 0, 0, 0), 1, 'x});
      rows.push_back('{make_beat(CMD_WR_DESC, 15, 0, 0, 0, 0, 8'hff, 1, 16, 0, 0), 1, 'x});
      rows.push_back('{make_beat(CMD_WR_DESC, 1, 0, 0, 0, 0, 8'h00, 17, 31, 0, 0), 1, 'x});
      rows.push_back('{make_beat(CMD_WR_EVENT, 0, 0, 3, 0, 0, 0, 0, 0, 0, 1), 1, 'x});
      rows.push_back('{make_beat(CMD_WR_EVENT, 0, 0, 3, 7, 0, 0, 0, 0, 23, 59), 1, 'x});
      rows.push_back('{make_beat(CMD_WR_EVENT, 15, 0, 8, 0, 0, 0, 0, 0, 12, 0), 1, 'x});
      rows.push_back('{make_beat(CMD_WR_EVENT, 15, 0, 7, 1, 0, 0, 0, 0, 6, 30), 1, 'x});
      rows.push_back('{make_beat(CMD_WR_EVENT, 2, 0, 9, 0, 0, 0, 0, 0, 1, 1), 1, 'x});
      rows.push_back('{make_beat(CMD_EVALUATE, 0, 0, 3, 0, 365, 0, 0, 0, 23, 59), 0, '0});
      rows.push_back('{make_beat(CMD_EVALUATE, 0, 0, 3, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_beat(CMD_EVALUATE, 0, 0, 3, 0, 367, 0, 0, 0, 12, 0), 0, '0});
      rows.push_back('{make_beat(CMD_EVALUATE, 0, 0, 15, 0, 511, 0, 0, 0, 31, 63), 0, '0});
      rows.push_back('{make_beat(CMD_WR_FLAG, 0, 0, 0, 0, 0, 8'hff, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_beat(CMD_EVALUATE, 0, 0, 0, 0, 100, 0, 0, 0, 12, 30), 0, '0});

      repeat (8) @(posedge clock);
      reset <= 0;
      foreach (rows[r]) begin
         // flag-only rows are typed in only where the state is obvious
         send_beat(rows[r].beat, rows[r].has_rsp && rows[r].rsp !== 'x, rows[r].rsp);
         if (r == 2) begin
            typed_rsps[$] = '{16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0};
         end
         idle_gap();
      end
      for (int n = 0; n < N_RANDOM; n++) begin
         b = random_beat();
         send_beat(b, 0, '0);
         if (n == 300) long_hold = 1;
         idle_gap();
      end
      req_valid <= 0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (n_errors == 0) begin
         $display("weekly_annual_schedule_evaluator regression: pass");
      end else begin
         $display("weekly_annual_schedule_evaluator regression: fail");
      end
      $finish;
   end

   // receiver stall pattern with one long hold-off
   initial begin
      int phase;
      phase = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 0;
            rsp_ready <= 0;
            repeat (3000) @(posedge clock);
         end
         phase = (phase + 1) % 64;
         rsp_ready <= (phase < 24) ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      sched_rsp_t e, a, t;
      bit tv;
      if (!reset && rsp_valid && rsp_ready) begin
         a = '{rsp_weekly_on, rsp_annual_on, rsp_holiday_one_hit, rsp_holiday_two_hit,
               rsp_weekly_toggled, rsp_annual_toggled};
         if (expected_rsps.size() == 0) begin
            $error("result beat with nothing expected");
            n_errors++;
         end else begin
            e = expected_rsps.pop_front();
            t = typed_rsps.pop_front();
            tv = typed_valid.pop_front();
            if (tv && t !== e) begin
               $error("typed row disagrees with model: %h vs %h", t, e);
               n_errors++;
            end
            if (a.weekly_on !== e.weekly_on) begin
               $error("weekly_on exp %h got %h", e.weekly_on, a.weekly_on); n_errors++;
            end
            if (a.annual_on !== e.annual_on) begin
               $error("annual_on exp %h got %h", e.annual_on, a.annual_on); n_errors++;
            end
            if (a.holiday_one_hit !== e.holiday_one_hit) begin
               $error("holiday_one_hit exp %h got %h", e.holiday_one_hit,
                      a.holiday_one_hit);
               n_errors++;
            end
            if (a.holiday_two_hit !== e.holiday_two_hit) begin
               $error("holiday_two_hit exp %h got %h", e.holiday_two_hit,
                      a.holiday_two_hit);
               n_errors++;
            end
            if (a.weekly_toggled !== e.weekly_toggled) begin
               $error("weekly_toggled exp %b got %b", e.weekly_toggled,
                      a.weekly_toggled);
               n_errors++;
            end
            if (a.annual_toggled !== e.annual_toggled) begin
               $error("annual_toggled exp %b got %b", e.annual_toggled,
                      a.annual_toggled);
               n_errors++;
            end
         end
      end
   end

endmodule

// ===== sim.f =====
rtl/wase_pkg.sv
rtl/wase_ctrl.sv
rtl/wase_dpath.sv
rtl/weekly_annual_schedule_evaluator.sv
tb/sv/tb_weekly_annual_schedule_evaluator.sv
